// File: design/crb_pkg.sv
// ----------------------------------------------------------------------------
// crb_pkg
// Shared codes and widths for the connection retry backoff block.
// ----------------------------------------------------------------------------
package crb_pkg;

  // Field widths
  localparam int unsigned KIND_W  = 3;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned DELAY_W = 32;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [KIND_W-1:0]  kind_t;
  typedef logic [MODE_W-1:0]  mode_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Event codes
  localparam kind_t EV_RESET     = 3'd0;
  localparam kind_t EV_START     = 3'd1;
  localparam kind_t EV_PROVISION = 3'd2;
  localparam kind_t EV_CREDS     = 3'd3;
  localparam kind_t EV_SUCCESS   = 3'd4;
  localparam kind_t EV_FAILURE   = 3'd5;
  localparam kind_t EV_RETRY     = 3'd6;
  localparam kind_t EV_STOP      = 3'd7;

  // Mode codes
  localparam mode_t MODE_INIT       = 3'd0;
  localparam mode_t MODE_PORTAL     = 3'd1;
  localparam mode_t MODE_CONNECTING = 3'd2;
  localparam mode_t MODE_WAITING    = 3'd3;
  localparam mode_t MODE_CONNECTED  = 3'd4;
  localparam mode_t MODE_STOPPED    = 3'd5;

  // Configuration register indexes
  localparam cfg_idx_t REG_ATTEMPT_LIMIT = 2'd0;
  localparam cfg_idx_t REG_FIRST_DELAY   = 2'd1;
  localparam cfg_idx_t REG_DELAY_CAP     = 2'd2;

  // Reset values of the configuration registers
  localparam count_t LIMIT_RST       = 8'd5;
  localparam delay_t FIRST_DELAY_RST = 32'd1000;
  localparam delay_t DELAY_CAP_RST   = 32'd60000;

endpackage

// File: design/connection_retry_backoff_fsm.sv
// ----------------------------------------------------------------------------
// connection_retry_backoff_fsm
// Link connection manager with capped exponential retry backoff. Each input
// word is one event (reset, start, provision request, credentials, success,
// failure, retry elapsed, stop); each event yields exactly one result word
// with the new mode, the failed-attempt count and the retry delay in ms.
// The block takes one event per cycle when not stalled. An event passes
// through an input register, then the mode/count/delay update and backoff
// shift, then the result register. The state update loop (count increment,
// limit compare, 64-bit shift and cap compare) sets that rate. The input
// side keeps accepting while a result waits, and stalls only when both the
// input and result registers are full and out_stall is high. Configuration
// writes are always ready and should be made with no events in flight.
// ----------------------------------------------------------------------------
module connection_retry_backoff_fsm
  import crb_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  // event input
  input  logic     in_valid,
  output logic     in_stall,
  input  kind_t    in_kind,
  input  logic     in_force_portal,
  input  logic     in_has_credentials,
  // result output
  output logic     out_valid,
  input  logic     out_stall,
  output mode_t    out_mode,
  output count_t   out_attempt_count,
  output delay_t   out_retry_delay_ms,
  // configuration writes
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  cfg_idx_t cfg_index,
  input  delay_t   cfg_data
);

  // configuration registers
  count_t limit_r;
  delay_t first_r;
  delay_t cap_r;

  // input register
  logic   s1_valid_r;
  kind_t  s1_kind_r;
  logic   s1_force_r;
  logic   s1_creds_r;

  // block state
  mode_t  mode_r,     mode_nxt;
  count_t attempts_r, attempts_nxt;
  delay_t delay_r,    delay_nxt;

  // result register
  logic   out_valid_r;
  mode_t  out_mode_r;
  count_t out_count_r;
  delay_t out_delay_r;

  logic   s1_go;
  logic   s1_load;
  count_t attempts_inc;
  delay_t backoff;

  // handshake
  assign s1_go     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = s1_valid_r && out_valid_r && out_stall;
  assign s1_load   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RST;
      first_r <= FIRST_DELAY_RST;
      cap_r   <= DELAY_CAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ATTEMPT_LIMIT: limit_r <= cfg_data[COUNT_W-1:0];
        REG_FIRST_DELAY:   first_r <= cfg_data;
        REG_DELAY_CAP:     cap_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_load) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_kind_r  <= in_kind;
      s1_force_r <= in_force_portal;
      s1_creds_r <= in_has_credentials;
    end
  end

  // backoff for the incremented count
  assign attempts_inc = attempts_r + count_t'(1);

  crb_backoff u_backoff (
    .attempts    (attempts_inc),
    .first_delay (first_r),
    .delay_cap   (cap_r),
    .delay       (backoff)
  );

  // event decode
  always_comb begin
    mode_nxt     = mode_r;
    attempts_nxt = '0;
    delay_nxt    = '0;
    unique case (s1_kind_r)
      EV_RESET:     mode_nxt = MODE_INIT;
      EV_START:     mode_nxt = (s1_force_r || !s1_creds_r) ? MODE_PORTAL : MODE_CONNECTING;
      EV_PROVISION: mode_nxt = MODE_PORTAL;
      EV_CREDS:     mode_nxt = MODE_CONNECTING;
      EV_SUCCESS:   mode_nxt = MODE_CONNECTED;
      EV_FAILURE: begin
        if (limit_r == '0) begin
          // zero limit: straight to portal, count untouched
          mode_nxt     = MODE_PORTAL;
          attempts_nxt = attempts_r;
        end else begin
          attempts_nxt = attempts_inc;
          if (attempts_inc < limit_r) begin
            mode_nxt  = MODE_WAITING;
            delay_nxt = backoff;
          end else begin
            mode_nxt  = MODE_PORTAL;
          end
        end
      end
      EV_RETRY: begin
        mode_nxt     = MODE_CONNECTING;
        attempts_nxt = attempts_r;
        delay_nxt    = delay_r;
      end
      EV_STOP:      mode_nxt = MODE_STOPPED;
      default:      mode_nxt = mode_r;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_INIT;
      attempts_r <= '0;
      delay_r    <= '0;
    end else if (s1_go) begin
      mode_r     <= mode_nxt;
      attempts_r <= attempts_nxt;
      delay_r    <= delay_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_mode_r  <= mode_nxt;
      out_count_r <= attempts_nxt;
      out_delay_r <= delay_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_mode           = out_mode_r;
  assign out_attempt_count  = out_count_r;
  assign out_retry_delay_ms = out_delay_r;

  // assertions
  a_delay_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (delay_r != '0) |-> (mode_r == MODE_WAITING || mode_r == MODE_CONNECTING))
    else $error("nonzero delay outside waiting/connecting");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> s1_valid_r)
    else $error("input register dropped a stalled event");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a buffered event");

  a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= MODE_STOPPED)
    else $error("mode out of range");

endmodule

// File: design/crb_backoff.sv
// ----------------------------------------------------------------------------
// crb_backoff
// Capped exponential delay: min(first << (attempts - 1), cap), zero when
// either setting is zero. One barrel shift and one compare.
// ----------------------------------------------------------------------------
module crb_backoff
  import crb_pkg::*;
(
  input  count_t attempts,
  input  delay_t first_delay,
  input  delay_t delay_cap,
  output delay_t delay
);

  count_t                 shift_amt;
  logic                   shift_big;
  logic [2*DELAY_W-1:0]   shifted;
  logic                   over_cap;

  // a count of 0 (after wrap) or 1 means no doubling
  assign shift_amt = (attempts == '0) ? '0 : attempts - count_t'(1);
  // 32 or more doublings of a nonzero value always exceed a 32-bit cap
  assign shift_big = (shift_amt[COUNT_W-1:5] != '0);
  assign shifted   = {{DELAY_W{1'b0}}, first_delay} << shift_amt[4:0];

  assign over_cap = shift_big || (shifted[2*DELAY_W-1:DELAY_W] != '0) ||
                    (shifted[DELAY_W-1:0] >= delay_cap);

  always_comb begin
    if ((first_delay == '0) || (delay_cap == '0)) begin
      delay = '0;
    end else if (over_cap) begin
      delay = delay_cap;
    end else begin
      delay = shifted[DELAY_W-1:0];
    end
  end

endmodule
